FILE: hw/rtl/heightmap_bilinear_sampler_defines.svh
// Assertion macros used by the checker of the heightmap sampler.
// Depends on nothing; each macro takes a label, clock, active-low reset and two expressions.
`ifndef HEIGHTMAP_BILINEAR_SAMPLER_DEFINES_SVH
`define HEIGHTMAP_BILINEAR_SAMPLER_DEFINES_SVH

// Same-cycle implication.
`define HBS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication.
`define HBS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

FILE: hw/rtl/hbs_pkg.sv
// Package of the heightmap sampler: grid sizes, widths, codes, types.
// Used by every RTL file of the block; depends on nothing.
`default_nettype none

package hbs_pkg;

    localparam int GRID_X_MAX = 256;
    localparam int GRID_Z_MAX = 256;
    localparam int X_W        = $clog2(GRID_X_MAX);
    localparam int Z_W        = $clog2(GRID_Z_MAX);
    localparam int ADDR_W     = X_W + Z_W;

    localparam int DIM_W   = 9;    // grid size registers
    localparam int SCALE_W = 16;   // cell scale, unsigned Q8.8
    localparam int POS_W   = 24;   // world position, signed Q16.8
    localparam int H_W     = 16;   // height, signed Q8.8
    localparam int FRAC_W  = 8;
    localparam int DIV_W   = 32;   // dividend and quotient of the shared divider
    localparam int CNT_W   = $clog2(DIV_W);
    localparam int W_W     = FRAC_W + 1;  // blend weight 0..256
    localparam int V_W     = 25;   // one-axis blend, up to 256 * 32768
    localparam int ACC_W   = 33;   // two-axis blend

    localparam logic [DIM_W-1:0] GRID_X_LIM = DIM_W'(GRID_X_MAX);
    localparam logic [DIM_W-1:0] GRID_Z_LIM = DIM_W'(GRID_Z_MAX);
    localparam logic [W_W-1:0]   W_ONE      = W_W'(1 << FRAC_W);

    localparam logic [1:0] FUNC_SAMPLE = 2'd0;
    localparam logic [1:0] FUNC_WRITE  = 2'd1;
    localparam logic [1:0] FUNC_READ   = 2'd2;

    localparam logic [1:0] REG_GRID_WIDTH = 2'd0;
    localparam logic [1:0] REG_GRID_DEPTH = 2'd1;
    localparam logic [1:0] REG_CELL_SCALE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_X,
        ST_DIV_Z,
        ST_CORNER,
        ST_BLEND,
        ST_READ,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
    } t_div_req;

    typedef struct packed {
        logic           en;
        logic           clr;
        logic [W_W-1:0] weight;
    } t_mac_ctrl;

endpackage

`default_nettype wire

FILE: hw/rtl/heightmap_bilinear_sampler.sv
// A sample runs two 32-step divisions, four corner fetches with multiply-accumulate and three
// blend steps, ending early on a zero scale or bad position, or on leaving the grid after the
// divisions; a read in the grid waits for the registered data; others go straight to the result.
// Items are taken one at a time: a new one is accepted only once the last result is handed over.
// Reset: synchronous active low; clears control and registers to width 256, depth 256, scale 256.
// The height grid is not cleared by reset.
`default_nettype none

module heightmap_bilinear_sampler (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire  [3:0]                       paddr,
    input  wire  [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  wire  [1:0]                       i_func,
    input  wire  signed [hbs_pkg::POS_W-1:0] i_pos_x,
    input  wire  signed [hbs_pkg::POS_W-1:0] i_pos_z,
    input  wire  [7:0]                       i_cell_x,
    input  wire  [7:0]                       i_cell_z,
    input  wire  signed [hbs_pkg::H_W-1:0]   i_height_in,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output logic signed [hbs_pkg::H_W-1:0]   o_height_out,
    output logic                             o_status
);
    import hbs_pkg::*;

    // configuration registers
    logic [DIM_W-1:0]    r_grid_w, r_grid_d;
    logic [SCALE_W-1:0]  r_scale;
    logic [DIM_W-1:0]    eff_w, eff_d;
    logic                cfg_wr;

    // sequencer
    t_state              r_state, n_state;
    logic [2:0]          r_step, n_step;
    logic [DIV_W-1:0]    r_nz, n_nz;
    logic [DIV_W-1:0]    r_qx, n_qx;
    logic [X_W-1:0]      r_col, n_col;
    logic [Z_W-1:0]      r_row, n_row;
    logic [FRAC_W-1:0]   r_fx, n_fx;
    logic [FRAC_W-1:0]   r_fz, n_fz;
    logic signed [V_W-1:0] r_t1, n_t1;
    logic signed [V_W-1:0] r_t2, n_t2;
    logic [ADDR_W-1:0]   r_raddr, n_raddr;
    logic [H_W-1:0]      r_res_h, n_res_h;
    logic                r_res_s, n_res_s;
    logic                r_out_valid, n_out_valid;
    logic [H_W-1:0]      r_out_h, n_out_h;
    logic                r_out_s, n_out_s;

    // datapath links
    t_div_req            div_req;
    logic                div_done;
    logic [DIV_W-1:0]    div_q;
    t_mac_ctrl           mac_ctrl;
    logic signed [V_W-1:0]   mac_value;
    logic signed [ACC_W-1:0] mac_acc;
    logic signed [ACC_W-1:0] rounded;
    logic                mem_we;
    logic [H_W-1:0]      rdata;
    logic signed [V_W-1:0]   rdata_ext;

    logic                in_acc;
    logic                cell_inside;
    logic                pos_z_bad;
    logic [POS_W-1:0]    nz_mag;
    logic [DIV_W-1:0]    dividend_x, dividend_z;
    logic                span_ok;
    logic [W_W-1:0]      wx0, wz0, wx1, wz1;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_w <= DIM_W'(256);
            r_grid_d <= DIM_W'(256);
            r_scale  <= SCALE_W'(256);
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_GRID_WIDTH: r_grid_w <= pwdata[DIM_W-1:0];
                REG_GRID_DEPTH: r_grid_d <= pwdata[DIM_W-1:0];
                REG_CELL_SCALE: r_scale  <= pwdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_GRID_WIDTH: prdata = {{(32-DIM_W){1'b0}}, r_grid_w};
            REG_GRID_DEPTH: prdata = {{(32-DIM_W){1'b0}}, r_grid_d};
            REG_CELL_SCALE: prdata = {{(32-SCALE_W){1'b0}}, r_scale};
            default:        prdata = '0;
        endcase
    end

    assign eff_w = (r_grid_w > GRID_X_LIM) ? GRID_X_LIM : r_grid_w;
    assign eff_d = (r_grid_d > GRID_Z_LIM) ? GRID_Z_LIM : r_grid_d;

    // ---------------- input decode ----------------
    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_acc      = i_in_valid & o_in_ready;
    assign cell_inside = ({1'b0, i_cell_x} < eff_w) && ({1'b0, i_cell_z} < eff_d);

    // negated z is negative whenever z is positive
    assign pos_z_bad  = !i_pos_z[POS_W-1] && (i_pos_z != '0);
    assign nz_mag     = POS_W'(-i_pos_z);
    assign dividend_x = {1'b0, i_pos_x[POS_W-2:0], {FRAC_W{1'b0}}};
    assign dividend_z = {nz_mag, {FRAC_W{1'b0}}};

    // both the left column and its right neighbor, both rows, must be in the grid
    assign span_ok = (({1'b0, r_qx[DIV_W-1:FRAC_W]} + 25'd1) < {16'd0, eff_w})
                  && (({1'b0, div_q[DIV_W-1:FRAC_W]} + 25'd1) < {16'd0, eff_d});

    assign wx1 = {1'b0, r_fx};
    assign wz1 = {1'b0, r_fz};
    assign wx0 = W_ONE - wx1;
    assign wz0 = W_ONE - wz1;

    assign rdata_ext = {{(V_W-H_W){rdata[H_W-1]}}, rdata};
    assign rounded   = mac_acc + ACC_W'(32768);

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_nz    <= n_nz;
        r_qx    <= n_qx;
        r_col   <= n_col;
        r_row   <= n_row;
        r_fx    <= n_fx;
        r_fz    <= n_fz;
        r_t1    <= n_t1;
        r_t2    <= n_t2;
        r_raddr <= n_raddr;
        r_res_h <= n_res_h;
        r_res_s <= n_res_s;
        r_out_h <= n_out_h;
        r_out_s <= n_out_s;
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_nz        = r_nz;
        n_qx        = r_qx;
        n_col       = r_col;
        n_row       = r_row;
        n_fx        = r_fx;
        n_fz        = r_fz;
        n_t1        = r_t1;
        n_t2        = r_t2;
        n_raddr     = r_raddr;
        n_res_h     = r_res_h;
        n_res_s     = r_res_s;
        n_out_valid = r_out_valid & ~i_out_ready;
        n_out_h     = r_out_h;
        n_out_s     = r_out_s;
        div_req     = '0;
        mac_ctrl    = '0;
        mac_value   = rdata_ext;
        mem_we      = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_res_h = '0;
                    n_res_s = 1'b0;
                    n_step  = '0;
                    case (i_func)
                        FUNC_SAMPLE: begin
                            if (r_scale == '0 || i_pos_x[POS_W-1] || pos_z_bad) begin
                                n_res_s = 1'b1;
                                n_state = ST_FINISH;
                            end else begin
                                div_req.start    = 1'b1;
                                div_req.dividend = dividend_x;
                                n_nz             = dividend_z;
                                n_state          = ST_DIV_X;
                            end
                        end
                        FUNC_WRITE: begin
                            mem_we  = cell_inside;
                            n_res_s = ~cell_inside;
                            n_state = ST_FINISH;
                        end
                        FUNC_READ: begin
                            if (cell_inside) begin
                                n_raddr = {i_cell_z[Z_W-1:0], i_cell_x[X_W-1:0]};
                                n_state = ST_READ;
                            end else begin
                                n_res_s = 1'b1;
                                n_state = ST_FINISH;
                            end
                        end
                        default: n_state = ST_FINISH;
                    endcase
                end
            end
            ST_DIV_X: begin
                if (div_done) begin
                    n_qx             = div_q;
                    div_req.start    = 1'b1;
                    div_req.dividend = r_nz;
                    n_state          = ST_DIV_Z;
                end
            end
            ST_DIV_Z: begin
                if (div_done) begin
                    if (span_ok) begin
                        n_col   = r_qx[FRAC_W +: X_W];
                        n_fx    = r_qx[FRAC_W-1:0];
                        n_row   = div_q[FRAC_W +: Z_W];
                        n_fz    = div_q[FRAC_W-1:0];
                        n_raddr = {div_q[FRAC_W +: Z_W], r_qx[FRAC_W +: X_W]};
                        n_step  = '0;
                        n_state = ST_CORNER;
                    end else begin
                        n_res_s = 1'b1;
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_CORNER: begin
                // even step: wait for read data; odd: accumulate, fetch next corner or blend
                n_step = r_step + 3'd1;
                case (r_step)
                    3'd1: begin
                        mac_ctrl = '{en: 1'b1, clr: 1'b1, weight: wz0};
                        n_raddr  = {r_row + Z_W'(1), r_col};
                    end
                    3'd3: begin
                        mac_ctrl = '{en: 1'b1, clr: 1'b0, weight: wz1};
                        n_raddr  = {r_row, r_col + X_W'(1)};
                    end
                    3'd4: begin
                        n_t1 = mac_acc[V_W-1:0];
                    end
                    3'd5: begin
                        mac_ctrl = '{en: 1'b1, clr: 1'b1, weight: wz0};
                        n_raddr  = {r_row + Z_W'(1), r_col + X_W'(1)};
                    end
                    3'd7: begin
                        mac_ctrl = '{en: 1'b1, clr: 1'b0, weight: wz1};
                        n_step   = '0;
                        n_state  = ST_BLEND;
                    end
                    default: ;
                endcase
            end
            ST_BLEND: begin
                n_step = r_step + 3'd1;
                case (r_step)
                    3'd0: begin
                        n_t2      = mac_acc[V_W-1:0];
                        mac_ctrl  = '{en: 1'b1, clr: 1'b1, weight: wx0};
                        mac_value = r_t1;
                    end
                    3'd1: begin
                        mac_ctrl  = '{en: 1'b1, clr: 1'b0, weight: wx1};
                        mac_value = r_t2;
                    end
                    default: begin
                        // round half up, then drop the 16 fraction bits
                        n_res_h = rounded[H_W+15:16];
                        n_res_s = 1'b0;
                        n_state = ST_FINISH;
                    end
                endcase
            end
            ST_READ: begin
                n_step = r_step + 3'd1;
                if (r_step[0]) begin
                    n_res_h = rdata;
                    n_res_s = 1'b0;
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // hand over once the output register is free or being drained
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_h     = r_res_h;
                    n_out_s     = r_res_s;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_out_valid  = r_out_valid;
    assign o_height_out = r_out_h;
    assign o_status     = r_out_s;

    // ---------------- shared units ----------------
    hbs_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .i_divisor  (r_scale),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    hbs_mac u_mac (
        .i_clk   (i_clk),
        .i_ctrl  (mac_ctrl),
        .i_value (mac_value),
        .o_acc   (mac_acc)
    );

    hbs_grid_store u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr ({i_cell_z[Z_W-1:0], i_cell_x[X_W-1:0]}),
        .i_wdata (i_height_in),
        .i_raddr (r_raddr),
        .o_rdata (rdata)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/hbs_divider.sv
// Shared restoring divider of the heightmap sampler: one quotient bit per cycle.
// Depends on hbs_pkg.
`default_nettype none

module hbs_divider (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire  hbs_pkg::t_div_req      i_req,
    input  wire  [hbs_pkg::SCALE_W-1:0]  i_divisor,
    output logic                         o_done,
    output logic [hbs_pkg::DIV_W-1:0]    o_quotient
);
    import hbs_pkg::*;

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [DIV_W-1:0]     r_quo, n_quo;
    logic [SCALE_W-1:0]   r_rem, n_rem;
    logic [SCALE_W-1:0]   r_dsr, n_dsr;
    logic [SCALE_W:0]     trial;
    logic [SCALE_W:0]     diff;
    logic                 fits;

    // shift the next dividend bit into the partial remainder
    assign trial = {r_rem, r_quo[DIV_W-1]};
    assign diff  = trial - {1'b0, r_dsr};
    assign fits  = trial >= {1'b0, r_dsr};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dsr  = r_dsr;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_req.dividend;
            n_rem  = '0;
            n_dsr  = i_divisor;
        end else if (r_busy) begin
            n_quo = {r_quo[DIV_W-2:0], fits};
            n_rem = fits ? diff[SCALE_W-1:0] : trial[SCALE_W-1:0];
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(DIV_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dsr <= n_dsr;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

FILE: hw/rtl/hbs_mac.sv
// Shared multiply-accumulate unit of the heightmap sampler: weight times value per cycle while enabled.
// Depends on hbs_pkg.
`default_nettype none

module hbs_mac (
    input  wire                                 i_clk,
    input  wire hbs_pkg::t_mac_ctrl             i_ctrl,
    input  wire signed [hbs_pkg::V_W-1:0]       i_value,
    output logic signed [hbs_pkg::ACC_W-1:0]    o_acc
);
    import hbs_pkg::*;

    logic signed [W_W+V_W:0]  product;
    logic signed [ACC_W-1:0]  base;
    logic signed [ACC_W-1:0]  r_acc, n_acc;

    assign product = $signed({1'b0, i_ctrl.weight}) * i_value;
    assign base    = i_ctrl.clr ? '0 : r_acc;

    always_comb begin
        n_acc = r_acc;
        if (i_ctrl.en) begin
            n_acc = base + $signed(product[ACC_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire

FILE: hw/rtl/hbs_grid_store.sv
// Height grid of the heightmap sampler: one write port, one registered read port.
// Depends on hbs_pkg.
`default_nettype none

module hbs_grid_store (
    input  wire                          i_clk,
    input  wire                          i_we,
    input  wire  [hbs_pkg::ADDR_W-1:0]   i_waddr,
    input  wire  [hbs_pkg::H_W-1:0]      i_wdata,
    input  wire  [hbs_pkg::ADDR_W-1:0]   i_raddr,
    output logic [hbs_pkg::H_W-1:0]      o_rdata
);
    import hbs_pkg::*;

    logic [H_W-1:0] mem [GRID_X_MAX*GRID_Z_MAX];
    logic [H_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hw/rtl/hbs_checker.sv
// Port-level checker of the heightmap sampler, bound to the top level.
// Depends on heightmap_bilinear_sampler_defines.svh and hbs_pkg.
`default_nettype none

`include "heightmap_bilinear_sampler_defines.svh"

module hbs_checker (
    input wire                           i_clk,
    input wire                           i_rst_n,
    input wire                           i_in_valid,
    input wire                           o_in_ready,
    input wire                           o_out_valid,
    input wire                           i_out_ready,
    input wire [hbs_pkg::H_W-1:0]        o_height_out,
    input wire                           o_status
);
    import hbs_pkg::*;

    logic out_stall;

    assign out_stall = o_out_valid && !i_out_ready;

    // an accepted beat makes the block busy in the next cycle
    `HBS_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

    // an out-of-grid or rejected item always reports height zero
    `HBS_ASSERT_IMP(a_status_zero, i_clk, i_rst_n, o_out_valid && o_status, o_height_out == '0)

    // a stalled result beat holds
    `HBS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid)

    `HBS_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, out_stall, $stable({o_height_out, o_status}))

endmodule

bind heightmap_bilinear_sampler hbs_checker u_hbs_checker (.*);

`default_nettype wire
